FILE: hdl/spq_pkg.sv
// spq_pkg: sizes, operation and status codes and shared types of the sorted priority queue
// no dependencies; compiled first

package spq_pkg;

    localparam int DEPTH  = 8;
    localparam int KEY_W  = 32;
    localparam int TAG_W  = 8;
    localparam int CAP_W  = 4;
    localparam int OCC_W  = 4;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int LIM_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_DUP   = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_res_t;

endpackage

FILE: hdl/spq_req_if.sv
// spq_req_if: request channel of the sorted priority queue
// depends on spq_pkg

interface spq_req_if;
    import spq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [KEY_W-1:0]  new_priority;
    logic [TAG_W-1:0]         new_tag;

    modport source (output valid, kind, new_priority, new_tag, input ready);
    modport sink   (input valid, kind, new_priority, new_tag, output ready);
endinterface

FILE: hdl/spq_rsp_if.sv
// spq_rsp_if: result channel of the sorted priority queue
// depends on spq_pkg

interface spq_rsp_if;
    import spq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [KEY_W-1:0]  out_priority;
    logic [TAG_W-1:0]         out_tag;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, status, out_priority, out_tag, occupancy, input ready);
    modport sink   (input valid, status, out_priority, out_tag, occupancy, output ready);
endinterface

FILE: hdl/spq_cfg_if.sv
// spq_cfg_if: capacity register write channel of the sorted priority queue
// depends on spq_pkg

interface spq_cfg_if;
    import spq_pkg::*;

    logic              valid;
    logic              ready;
    logic [CAP_W-1:0]  capacity;

    modport source (output valid, capacity, input ready);
    modport sink   (input valid, capacity, output ready);
endinterface

FILE: hdl/spq_cmp.sv
// spq_cmp: shared key comparator, equality and signed greater-than
// depends on spq_pkg

module spq_cmp (
    input  logic signed [spq_pkg::KEY_W-1:0] lhs,
    input  logic signed [spq_pkg::KEY_W-1:0] rhs,
    output spq_pkg::cmp_res_t                res
);
    import spq_pkg::*;

    always_comb
    begin
        res.eq = (lhs == rhs);
        res.gt = (lhs > rhs);
    end

endmodule

FILE: hdl/sorted_priority_queue_core.sv
// sorted_priority_queue_core: top level of the sorted priority queue
// depends on spq_pkg, spq_req_if, spq_rsp_if, spq_cfg_if and spq_cmp

// Bounded priority queue of DEPTH entries kept in ascending signed priority
// order in a one-write, one-read key/tag memory. One request beat is taken at
// a time; a sequencer walks the memory with a single comparator. Clear, a
// refused insert, an empty pop, an insert into an empty queue and an unknown
// kind answer at the accepting edge. Other inserts run a duplicate scan from
// the bottom, then a shift pass from the top that moves each greater key up
// one slot and stops at the insertion point to drop the new key in; a
// duplicate ends the scan with ST_DUP. A pop reads the head, then moves each
// remaining entry down one slot. The sequencer handles one entry per cycle,
// as set by the single memory read port. The result beat is held in an
// output register; a new request can be taken as early as the cycle in which
// its predecessor's result is taken. The user must write capacity on the cfg
// channel only while the block is idle; the block itself does not enforce it.

module sorted_priority_queue_core (
    input  logic       clk,
    input  logic       rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp,
    spq_cfg_if.sink    cfg
);
    import spq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_DUP       = 6'b000010,
        S_INS       = 6'b000100,
        S_INS_HEAD  = 6'b001000,
        S_POP_HEAD  = 6'b010000,
        S_POP_SHIFT = 6'b100000
    } state_t;

    // sequencer state
    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CAP_W-1:0]        capacity_reg;

    // latched request
    logic signed [KEY_W-1:0] pri_reg, pri_next;
    logic [TAG_W-1:0]        tag_reg, tag_next;

    // result beat
    logic                    rsp_valid_reg, rsp_valid_next;
    logic [STAT_W-1:0]       status_reg, status_next;
    logic signed [KEY_W-1:0] opri_reg, opri_next;
    logic [TAG_W-1:0]        otag_reg, otag_next;

    // key and tag memory
    logic [KEY_W-1:0]        key_mem [DEPTH];
    logic [TAG_W-1:0]        tag_mem [DEPTH];
    logic [KEY_W-1:0]        key_rd_reg;
    logic [TAG_W-1:0]        tag_rd_reg;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [KEY_W-1:0]        wr_key;
    logic [TAG_W-1:0]        wr_tag;

    logic [LIM_W-1:0]        count_ext;
    logic [LIM_W-1:0]        cap_ext;
    logic [LIM_W-1:0]        limit;
    logic                    is_full;
    logic [CNT_W-1:0]        count_m1;
    logic [ADDR_W-1:0]       last_idx;
    logic                    req_fire;
    cmp_res_t                cmp;

    // the one comparator: stored key against the key being inserted
    spq_cmp u_cmp (
        .lhs (signed'(key_rd_reg)),
        .rhs (pri_reg),
        .res (cmp)
    );

    // limit is min(capacity, DEPTH)
    assign count_ext = LIM_W'(count_reg);
    assign cap_ext   = LIM_W'(capacity_reg);
    assign limit     = (cap_ext < LIM_W'(DEPTH)) ? cap_ext : LIM_W'(DEPTH);
    assign is_full   = (count_ext >= limit);
    assign count_m1  = count_reg - 1'b1;
    assign last_idx  = count_m1[ADDR_W-1:0];

    // a new beat is taken only when idle and the result register is free or draining
    assign req.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign req_fire  = req.valid && req.ready;

    assign cfg.ready = 1'b1;

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_priority = opri_reg;
    assign rsp.out_tag      = otag_reg;
    assign rsp.occupancy    = count_ext[OCC_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        pri_next       = pri_reg;
        tag_next       = tag_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        opri_next      = opri_reg;
        otag_next      = otag_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_key         = pri_reg;
        wr_tag         = tag_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    pri_next  = req.new_priority;
                    tag_next  = req.new_tag;
                    opri_next = '0;
                    otag_next = '0;
                    case (req.kind)
                        KIND_INSERT:
                        begin
                            if (is_full)
                            begin
                                rsp_valid_next = 1'b1;
                                status_next    = ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                // empty queue: goes straight into slot zero
                                wr_en          = 1'b1;
                                wr_addr        = '0;
                                wr_key         = req.new_priority;
                                wr_tag         = req.new_tag;
                                count_next     = CNT_W'(1);
                                rsp_valid_next = 1'b1;
                                status_next    = ST_OK;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_DUP;
                            end
                        end
                        KIND_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_valid_next = 1'b1;
                                status_next    = ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_POP_HEAD;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            count_next     = '0;
                            rsp_valid_next = 1'b1;
                            status_next    = ST_OK;
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                            status_next    = ST_OK;
                        end
                    endcase
                end
            end

            // bottom-up scan for an equal key
            S_DUP:
            begin
                if (cmp.eq)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = ST_DUP;
                    state_next     = S_IDLE;
                end
                else if (idx_reg == last_idx)
                begin
                    idx_next   = last_idx;
                    state_next = S_INS;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // top-down pass: move greater keys up one slot, drop the new key in
            S_INS:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg + 1'b1;
                if (cmp.gt)
                begin
                    wr_key = key_rd_reg;
                    wr_tag = tag_rd_reg;
                    if (idx_reg == '0)
                    begin
                        state_next = S_INS_HEAD;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
                else
                begin
                    count_next     = count_reg + 1'b1;
                    rsp_valid_next = 1'b1;
                    status_next    = ST_OK;
                    state_next     = S_IDLE;
                end
            end

            // every held key was greater: new key becomes the head
            S_INS_HEAD:
            begin
                wr_en          = 1'b1;
                wr_addr        = '0;
                count_next     = count_reg + 1'b1;
                rsp_valid_next = 1'b1;
                status_next    = ST_OK;
                state_next     = S_IDLE;
            end

            S_POP_HEAD:
            begin
                opri_next = signed'(key_rd_reg);
                otag_next = tag_rd_reg;
                if (count_reg == CNT_W'(1))
                begin
                    count_next     = '0;
                    rsp_valid_next = 1'b1;
                    status_next    = ST_OK;
                    state_next     = S_IDLE;
                end
                else
                begin
                    idx_next   = ADDR_W'(1);
                    state_next = S_POP_SHIFT;
                end
            end

            // move each remaining entry down one slot
            S_POP_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg - 1'b1;
                wr_key  = key_rd_reg;
                wr_tag  = tag_rd_reg;
                if (idx_reg == last_idx)
                begin
                    count_next     = count_m1;
                    rsp_valid_next = 1'b1;
                    status_next    = ST_OK;
                    state_next     = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory: one write, one registered read that follows the next index
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            tag_mem[wr_addr] <= wr_tag;
        end
        key_rd_reg <= key_mem[idx_next];
        tag_rd_reg <= tag_mem[idx_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            capacity_reg  <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                capacity_reg <= cfg.capacity;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pri_reg    <= pri_next;
        tag_reg    <= tag_next;
        status_reg <= status_next;
        opri_reg   <= opri_next;
        otag_reg   <= otag_next;
    end

endmodule
